// ===== hw/rtl/rbma_pkg.sv =====
package rbma_pkg;

	localparam int DEPTH = 64;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W = $clog2(QUEUE_DEPTH);
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IS_SIGNED     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_IN_USE  = 2'd3;

	localparam logic [1:0] WIDTH_8  = 2'd0;
	localparam logic [1:0] WIDTH_16 = 2'd1;
	localparam logic [1:0] WIDTH_32 = 2'd2;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        read_valid;
		logic [6:0]  fill_count;
		logic [31:0] running_sum;
		logic [31:0] average;
	} out_item_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_write_t;

	function automatic logic [31:0] width_mask(input logic [1:0] w);
		logic [31:0] m;
		begin
			case (w)
				WIDTH_8:  m = 32'h0000_00FF;
				WIDTH_16: m = 32'h0000_FFFF;
				default:  m = 32'hFFFF_FFFF;
			endcase
			return m;
		end
	endfunction

	function automatic logic [31:0] extend(input logic [31:0] raw, input logic [1:0] w,
			input logic sgn);
		logic [31:0] v;
		begin
			v = raw & width_mask(w);
			case (w)
				WIDTH_8: begin
					if (sgn && v[7]) v[31:8] = '1;
				end
				WIDTH_16: begin
					if (sgn && v[15]) v[31:16] = '1;
				end
				default: begin
				end
			endcase
			return v;
		end
	endfunction

endpackage

// ===== hw/rtl/rbma_front.sv =====
module rbma_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  rbma_pkg::in_item_t item,
	output logic              q_valid,
	input  logic              q_ready,
	output rbma_pkg::in_item_t q_item
);
	import rbma_pkg::*;

	in_item_t          entry_q [QUEUE_DEPTH];
	logic [QP_W-1:0]   wr_ptr_q;
	logic [QP_W-1:0]   rd_ptr_q;
	logic [QC_W-1:0]   cnt_q;
	logic              push;
	logic              pop;

	assign item_ready = (cnt_q != QC_W'(QUEUE_DEPTH));
	assign q_valid    = (cnt_q != '0);
	assign push       = item_valid && item_ready;
	assign pop        = q_valid && q_ready;

	// Only the kind bit and the sample travel on; anything other than a read is a write.
	always_comb begin
		q_item = entry_q[rd_ptr_q];
		q_item.kind = (entry_q[rd_ptr_q].kind == KIND_READ) ? KIND_READ : KIND_WRITE;
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/rbma_div.sv =====
module rbma_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                dividend,
	input  logic [rbma_pkg::CNT_W-1:0] divisor,
	output logic [31:0]                quotient,
	output logic                       busy,
	output logic                       done
);
	import rbma_pkg::*;

	logic [31:0]      dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [4:0]       step_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W:0]   trial;
	logic             fits;

	// One quotient bit per cycle; quotient bits shift into the dividend register.
	assign trial = {rem_q, dvd_q[31]};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient = dvd_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

// ===== hw/rtl/rbma_back.sv =====
module rbma_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rbma_pkg::cfg_write_t cfg,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  rbma_pkg::in_item_t   q_item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output rbma_pkg::out_item_t  result
);
	import rbma_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_START = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t           state_q;
	logic [31:0]      mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      sum_q;

	logic [1:0]       sample_width_q;
	logic             is_signed_q;
	logic             filter_enable_q;
	logic [6:0]       depth_q;

	in_item_t         cur_q;
	logic [31:0]      raw_s1;
	logic             raw_valid_s1;
	logic [31:0]      rdata_q;
	logic             rvalid_q;
	logic             neg_q;
	out_item_t        out_q;
	logic             out_valid_q;

	logic             pop;
	logic             exec_write;
	logic             exec_read;
	logic [PTR_W-1:0] rd_addr;
	logic [CNT_W-1:0] depth_eff;
	logic [CNT_W-1:0] wp_inc;
	logic [CNT_W-1:0] rp_inc;
	logic [31:0]      old_ext;
	logic [31:0]      wr_sample;
	logic [31:0]      new_ext;
	logic [31:0]      raw_ext;
	logic             neg;
	logic [31:0]      dividend;
	logic             div_start;
	logic [31:0]      div_quo;
	logic             div_busy;
	logic             div_done;
	logic [31:0]      avg;
	logic             out_load;

	always_comb begin
		if (depth_q == '0)              depth_eff = CNT_W'(1);
		else if (int'(depth_q) > DEPTH) depth_eff = CNT_W'(DEPTH);
		else                            depth_eff = CNT_W'(depth_q);
	end

	assign q_ready    = (state_q == ST_IDLE);
	assign pop        = q_ready && q_valid;
	assign rd_addr    = (q_item.kind == KIND_READ) ? rp_q : wp_q;
	assign exec_write = (state_q == ST_EXEC) && (cur_q.kind == KIND_WRITE);
	assign exec_read  = (state_q == ST_EXEC) && (cur_q.kind == KIND_READ) && (cnt_q != '0);

	assign wp_inc    = CNT_W'(wp_q) + 1'b1;
	assign rp_inc    = CNT_W'(rp_q) + 1'b1;
	// An entry never written since reset reads as zero.
	assign raw_ext   = extend(raw_valid_s1 ? raw_s1 : 32'h0, sample_width_q, is_signed_q);
	assign old_ext   = raw_ext;
	assign wr_sample = cur_q.sample & width_mask(sample_width_q);
	assign new_ext   = extend(wr_sample, sample_width_q, is_signed_q);

	// The divider works on magnitudes; a negative signed sum is negated before and after.
	assign neg       = is_signed_q && sum_q[31];
	assign dividend  = neg ? (32'h0 - sum_q) : sum_q;
	assign div_start = (state_q == ST_START);
	assign avg       = (neg_q ? (32'h0 - div_quo) : div_quo) & width_mask(sample_width_q);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || result_ready);

	rbma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (depth_eff),
		.quotient (div_quo),
		.busy     (div_busy),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			raw_s1       <= mem_q[rd_addr];
			raw_valid_s1 <= valid_q[rd_addr];
			cur_q        <= q_item;
		end
		if (exec_write) mem_q[wp_q] <= wr_sample;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			rdata_q  <= exec_read ? raw_ext : 32'h0;
			rvalid_q <= exec_read;
		end
		if (div_start) neg_q <= neg;
		if (out_load) begin
			out_q.read_data   <= rdata_q;
			out_q.read_valid  <= rvalid_q;
			out_q.fill_count  <= 7'(cnt_q);
			out_q.running_sum <= sum_q;
			out_q.average     <= avg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			valid_q         <= '0;
			wp_q            <= '0;
			rp_q            <= '0;
			cnt_q           <= '0;
			sum_q           <= '0;
			sample_width_q  <= WIDTH_8;
			is_signed_q     <= 1'b0;
			filter_enable_q <= 1'b0;
			depth_q         <= 7'd64;
			out_valid_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (exec_write) begin
				valid_q[wp_q] <= 1'b1;
				if (filter_enable_q) sum_q <= sum_q + new_ext - old_ext;
				if (cnt_q < depth_eff) cnt_q <= cnt_q + 1'b1;
				wp_q <= (wp_inc >= depth_eff) ? '0 : wp_inc[PTR_W-1:0];
			end
			if (exec_read) begin
				cnt_q <= cnt_q - 1'b1;
				rp_q  <= (rp_inc >= depth_eff) ? '0 : rp_inc[PTR_W-1:0];
			end

			if (cfg.we) begin
				case (cfg.index)
					CFG_SAMPLE_WIDTH:  sample_width_q <= cfg.data[1:0];
					CFG_IS_SIGNED:     is_signed_q    <= cfg.data[0];
					CFG_FILTER_ENABLE: begin
						filter_enable_q <= cfg.data[0];
						sum_q           <= '0;
					end
					CFG_DEPTH_IN_USE:  depth_q <= cfg.data;
					default: begin
					end
				endcase
			end

			if (out_load)          out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	assert property (@(posedge clk) disable iff (!arst_n) int'(cnt_q) <= DEPTH)
		else $error("fill count above store depth");

	assert property (@(posedge clk) disable iff (!arst_n) div_start |-> !div_busy)
		else $error("divider started while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		exec_read |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("read of a stored entry did not decrement the count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_done) |=> (state_q == ST_OUT))
		else $error("quotient finished but result stage not entered");

endmodule

// ===== hw/rtl/ring_buffer_moving_average_unit.sv =====
// Ring buffer with moving average.
// A request on the item channel (item_valid/item_ready) either writes a sample
// into the ring or reads the oldest stored entry. Every request produces exactly
// one result on the result channel (result_valid/result_ready) carrying the read
// data, the fill count, the moving sum and the sum divided by the depth in use.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register per
// cycle; the user must write it only while no request is in flight, as the
// block itself does not enforce this. A two-entry queue takes requests while
// the execution side is busy. Each request then passes from the queue through
// one store read, one update, one divider load, 32 steps of the bit-serial
// divider at one bit per cycle, a finishing step and the registering of the
// result; the next request leaves the queue only after that result is loaded.
// When the receiver stalls, the finished result holds in the output register and
// execution waits to deliver the next; the queue keeps accepting until full.
// Reset empties the queue and clears the store's valid bits, pointers, count and
// sum at once, so the block accepts requests in the first cycle after reset.
module ring_buffer_moving_average_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  rbma_pkg::in_item_t                   item,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output rbma_pkg::out_item_t                  result,
	input  logic                                 cfg_we,
	input  logic [rbma_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rbma_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import rbma_pkg::*;

	logic       q_valid;
	logic       q_ready;
	in_item_t   q_item;
	cfg_write_t cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	rbma_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item)
	);

	rbma_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	import rbma_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 75;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	in_item_t              item;
	logic                  result_valid;
	logic                  result_ready;
	out_item_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the ring, its pointers and the moving sum.
	logic [31:0]      ring_mem [DEPTH] = '{default: '0};
	logic [PTR_W-1:0] wr_ptr = '0;
	logic [PTR_W-1:0] rd_ptr = '0;
	logic [6:0]       entry_cnt = '0;
	logic [31:0]      sum_acc = '0;

	logic [1:0] cfg_width = WIDTH_8;
	logic       cfg_signed = 1'b0;
	logic       cfg_filter = 1'b0;
	logic [6:0] cfg_depth = 7'd64;

	out_item_t expected_results [$];
	out_item_t oldest;
	int        error_count = 0;
	bit        steady = 1'b0;

	ring_buffer_moving_average_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [31:0] width_bits();
		case (cfg_width)
			WIDTH_8:  return 32'h0000_00FF;
			WIDTH_16: return 32'h0000_FFFF;
			default:  return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] widen(logic [31:0] raw);
		case (cfg_width)
			WIDTH_8:  return cfg_signed ? {{24{raw[7]}}, raw[7:0]} : {24'b0, raw[7:0]};
			WIDTH_16: return cfg_signed ? {{16{raw[15]}}, raw[15:0]} : {16'b0, raw[15:0]};
			default:  return raw;
		endcase
	endfunction

	function automatic logic [6:0] active_depth();
		if (cfg_depth == 7'd0)
			return 7'd1;
		if (cfg_depth > DEPTH)
			return 7'(DEPTH);
		return cfg_depth;
	endfunction

	function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p, logic [6:0] d);
		logic [6:0] n;
		n = 7'(p) + 7'd1;
		return (n >= d) ? '0 : n[PTR_W-1:0];
	endfunction

	// Signed sums divide on the magnitude so the quotient truncates toward zero.
	function automatic logic [31:0] window_mean();
		logic [31:0] dd;
		logic [31:0] q;
		dd = 32'(active_depth());
		if (cfg_signed && sum_acc[31])
			q = 32'd0 - ((32'd0 - sum_acc) / dd);
		else
			q = sum_acc / dd;
		return q & width_bits();
	endfunction

	function automatic out_item_t compute_ring_result(in_item_t req);
		out_item_t  r;
		logic [6:0] d;
		logic [31:0] s;
		d = active_depth();
		r = '0;
		if (req.kind == KIND_WRITE) begin
			s = req.sample & width_bits();
			if (cfg_filter)
				sum_acc = sum_acc - widen(ring_mem[wr_ptr]);
			ring_mem[wr_ptr] = s;
			if (cfg_filter)
				sum_acc = sum_acc + widen(s);
			if (entry_cnt < d)
				entry_cnt = entry_cnt + 7'd1;
			wr_ptr = next_ptr(wr_ptr, d);
		end else if (entry_cnt != 7'd0) begin
			r.read_data = widen(ring_mem[rd_ptr]);
			r.read_valid = 1'b1;
			rd_ptr = next_ptr(rd_ptr, d);
			entry_cnt = entry_cnt - 7'd1;
		end
		r.fill_count = entry_cnt;
		r.running_sum = sum_acc;
		r.average = window_mean();
		return r;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_SAMPLE_WIDTH: cfg_width = val[1:0];
			CFG_IS_SIGNED:    cfg_signed = val[0];
			CFG_FILTER_ENABLE: begin
				cfg_filter = val[0];
				sum_acc = '0;
			end
			CFG_DEPTH_IN_USE: cfg_depth = val[6:0];
			default: begin
			end
		endcase
	endfunction

	function automatic int draw_gap();
		if (steady || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			error_count++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
		end
	endtask

	// Accepted requests are predicted at the edge that takes them; results are checked in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				apply_reg(cfg_index, cfg_data);
			if (item_valid && item_ready)
				expected_results.push_back(compute_ring_result(item));
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: result with no request outstanding: expected none, actual %p",
						$time, result);
				end else begin
					oldest = expected_results.pop_front();
					check_field("read_data", oldest.read_data, result.read_data);
					check_field("read_valid", 32'(oldest.read_valid), 32'(result.read_valid));
					check_field("fill_count", 32'(oldest.fill_count), 32'(result.fill_count));
					check_field("running_sum", oldest.running_sum, result.running_sum);
					check_field("average", oldest.average, result.average);
				end
			end
		end
	end

	initial begin : result_sink
		int n;
		result_ready = 1'b0;
		@(posedge clk);
		forever begin
			n = draw_gap();
			if (n > 0) begin
				result_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (result_valid !== 1'b1);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_item(logic kind, logic [31:0] sample);
		int       n;
		in_item_t req;
		n = draw_gap();
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		req.kind = kind;
		req.sample = sample;
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (item_ready !== 1'b1);
	endtask

	task automatic wait_all_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_sample();
		logic [31:0] edges [6] = '{32'h7F, 32'h80, 32'h7FFF, 32'h8000,
			32'h7FFF_FFFF, 32'h8000_0000};
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h1 << $urandom_range(0, 31);
			3: return edges[$urandom_range(0, 5)] ^ ($urandom() & 32'hFFFF_0000);
			default: return $urandom();
		endcase
	endfunction

	// Reads on an empty ring leave everything unchanged, whatever the sample bits are.
	task automatic test_empty_read();
		send_item(KIND_READ, 32'h0);
		send_item(KIND_WRITE, 32'hFFFF_FFFF);
		send_item(KIND_READ, 32'h0);
		send_item(KIND_READ, 32'hFFFF_FFFF);
		wait_all_results();
	endtask

	task automatic test_signed_window();
		set_reg(CFG_SAMPLE_WIDTH, 7'(WIDTH_8));
		set_reg(CFG_IS_SIGNED, 7'd1);
		set_reg(CFG_DEPTH_IN_USE, 7'd3);
		set_reg(CFG_FILTER_ENABLE, 7'd1);
		send_item(KIND_WRITE, 32'h0000_0080);
		send_item(KIND_WRITE, 32'h0000_007F);
		send_item(KIND_WRITE, 32'hFFFF_FFFF);
		send_item(KIND_WRITE, 32'h0000_0001);
		send_item(KIND_READ, 32'h0);
		wait_all_results();
	endtask

	// A depth of one makes every write overwrite the previous entry; code 3 acts as 32 bits.
	task automatic test_wide_samples();
		set_reg(CFG_SAMPLE_WIDTH, 7'(WIDTH_32));
		set_reg(CFG_IS_SIGNED, 7'd0);
		set_reg(CFG_DEPTH_IN_USE, 7'd1);
		set_reg(CFG_FILTER_ENABLE, 7'd1);
		send_item(KIND_WRITE, 32'hFFFF_FFFF);
		send_item(KIND_WRITE, 32'h0000_0001);
		send_item(KIND_READ, 32'h0);
		send_item(KIND_READ, 32'h0);
		wait_all_results();
		set_reg(CFG_SAMPLE_WIDTH, 7'd3);
		set_reg(CFG_IS_SIGNED, 7'd1);
		send_item(KIND_WRITE, 32'h8000_0000);
		send_item(KIND_READ, 32'h0);
		wait_all_results();
	endtask

	task automatic test_depth_limits();
		set_reg(CFG_SAMPLE_WIDTH, 7'(WIDTH_16));
		set_reg(CFG_DEPTH_IN_USE, 7'd0);
		send_item(KIND_WRITE, 32'h0000_8000);
		send_item(KIND_WRITE, 32'h0000_7FFF);
		wait_all_results();
		set_reg(CFG_DEPTH_IN_USE, 7'd127);
		send_item(KIND_WRITE, 32'h1234_8000);
		send_item(KIND_WRITE, 32'hFFFF_FFFF);
		send_item(KIND_WRITE, 32'h0000_0003);
		wait_all_results();
		// Shrinking the depth below the fill count keeps the count and wraps the pointers.
		set_reg(CFG_DEPTH_IN_USE, 7'd2);
		send_item(KIND_WRITE, 32'h0000_0001);
		send_item(KIND_READ, 32'h0);
		wait_all_results();
		set_reg(CFG_FILTER_ENABLE, 7'd0);
		send_item(KIND_WRITE, 32'h0000_ABCD);
		send_item(KIND_READ, 32'h0);
		wait_all_results();
	endtask

	task automatic test_random_traffic();
		int         n;
		logic [6:0] d;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 9))
				0: d = 7'd0;
				1: d = 7'd64;
				2: d = 7'd127;
				3: d = 7'($urandom_range(1, 127));
				default: d = 7'($urandom_range(1, 8));
			endcase
			set_reg(CFG_SAMPLE_WIDTH, 7'($urandom_range(0, 3)));
			set_reg(CFG_IS_SIGNED, 7'($urandom_range(0, 1)));
			set_reg(CFG_DEPTH_IN_USE, d);
			if ($urandom_range(0, 3) != 0)
				set_reg(CFG_FILTER_ENABLE, 7'($urandom_range(0, 1)));
			steady = (ph == 2);
			n = PHASE_ITEMS + $urandom_range(0, 10) - 5;
			for (int k = 0; k < n; k++) begin
				// Hold off new requests until the pipeline has fully drained.
				if (k == n / 2 && (ph == 3 || $urandom_range(0, 2) == 0))
					wait_all_results();
				send_item(($urandom_range(0, 9) < 4) ? KIND_READ : KIND_WRITE, pick_sample());
			end
			wait_all_results();
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_read();
		test_signed_window();
		test_wide_samples();
		test_depth_limits();
		test_random_traffic();
		wait_all_results();
		repeat (40) @(posedge clk);
		error_count += expected_results.size();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
